// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Each macro expects signals named clk
// and arst_n in the scope where it is used, and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define ART_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the next edge.
`define ART_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/art_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

	typedef logic [63:0] addr_t;
	typedef logic [2:0]  kind_t;

	// Operation codes carried in the opcode field; code 3 is a no-op.
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_LOAD   = 2'd2
	} opcode_t;

	// Name classes supplied by the host.
	localparam kind_t NK_HEAP  = 3'd0;
	localparam kind_t NK_STACK = 3'd1;
	localparam kind_t NK_VDSO  = 3'd2;
	localparam kind_t NK_ANON  = 3'd3;
	localparam kind_t NK_FILE  = 3'd4;

	// Region kinds held in the table and reported on a hit.
	localparam kind_t RK_HEAP      = 3'd0;
	localparam kind_t RK_STACK     = 3'd1;
	localparam kind_t RK_VDSO      = 3'd2;
	localparam kind_t RK_ANON      = 3'd3;
	localparam kind_t RK_FILE_TEXT = 3'd4;
	localparam kind_t RK_FILE_DATA = 3'd5;
	localparam kind_t RK_NONE      = 3'd0;

	// One stored region.
	typedef struct packed {
		addr_t start_addr;
		addr_t end_addr;
		kind_t kind;
	} entry_t;

	// Region kind from the name class; any class above anonymous is a file.
	function automatic kind_t kind_of(input kind_t name_kind, input logic exec_flag);
		kind_t k;
		if (name_kind <= NK_ANON) begin
			k = name_kind;
		end else if (exec_flag) begin
			k = RK_FILE_TEXT;
		end else begin
			k = RK_FILE_DATA;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/art_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat.
interface art_req_if;
	import art_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	addr_t       address;
	addr_t       length;
	kind_t       name_kind;
	logic        exec_flag;

	modport source (output valid, output opcode, output address, output length,
		output name_kind, output exec_flag, input ready);
	modport sink (input valid, input opcode, input address, input length,
		input name_kind, input exec_flag, output ready);
endinterface

// Response channel: one result per request beat.
interface art_rsp_if;
	import art_pkg::*;

	logic        valid;
	logic        ready;
	logic        hit;
	addr_t       region_start;
	addr_t       region_end;
	kind_t       region_kind;
	logic        table_full;

	modport source (output valid, output hit, output region_start, output region_end,
		output region_kind, output table_full, input ready);
	modport sink (input valid, input hit, input region_start, input region_end,
		input region_kind, input table_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/address_region_table.sv =====
// Address region table with lookup, insert (replacing overlaps) and load.
// Requests arrive on the req channel and each produces exactly one beat on
// the rsp channel. A request is taken only when the block is idle; ready
// then stays low until its response beat has been taken.
// All work goes through one read port on the entry memory and one set of
// 64-bit comparators, stepping through the table one entry per cycle; the
// memory read is registered and drains before each pass over the
// TABLE_ENTRIES entries (16 by default) ends. A lookup scans the table, an
// insert scans it and then searches for a slot, a load only searches for a
// slot, and an unknown opcode goes straight to the response.
// A response is held in its output register for as long as rsp.ready is
// low; no new request is taken meanwhile.
// Reset clears every valid bit at once, so the table is empty straight
// after reset and needs no clearing pass. A full table drops an insert or
// load and reports table_full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module address_region_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	art_req_if.sink    req,
	art_rsp_if.source  rsp
);
	import art_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOOKUP_END,
		ST_CLEAR_PREV,
		ST_FIND_SLOT,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t                  state_q;
	logic [1:0]              op_q;
	addr_t                   key_q;
	addr_t                   end_q;
	kind_t                   kind_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0]        rd_cnt_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	entry_t                  rd_data_s1;

	logic                    best_found_q;
	addr_t                   best_start_q;
	addr_t                   best_end_q;
	kind_t                   best_kind_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic                    match_found_q;
	logic [IDX_W-1:0]        match_idx_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;

	logic                    rsp_valid_q;
	logic                    hit_q;
	addr_t                   rstart_q;
	addr_t                   rend_q;
	kind_t                   rkind_q;
	logic                    full_q;

	entry_t                  mem_q [TABLE_ENTRIES];

	logic [IDX_W-1:0]        rd_addr;
	logic                    ent_valid;
	logic                    scan_live;
	logic                    lt_key;
	logic                    eq_key;
	logic                    gt_best;
	logic                    lt_end;
	logic                    take_best;
	logic                    clear_hit;
	logic                    scan_done;
	logic                    prev_overlap;
	logic                    slot_ok;
	logic [IDX_W-1:0]        slot_idx;
	logic                    mem_we;

	// Handshake outputs.
	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.region_start = rstart_q;
	assign rsp.region_end   = rend_q;
	assign rsp.region_kind  = rkind_q;
	assign rsp.table_full   = full_q;

	// Shared compare unit: the entry read last cycle against the key, the
	// best candidate so far and the end of the new region.
	always_comb begin
		rd_addr      = rd_cnt_q[IDX_W-1:0];
		ent_valid    = valid_q[rd_idx_s1];
		scan_live    = rd_vld_s1 && ent_valid;
		lt_key       = rd_data_s1.start_addr < key_q;
		eq_key       = rd_data_s1.start_addr == key_q;
		gt_best      = rd_data_s1.start_addr > best_start_q;
		lt_end       = rd_data_s1.start_addr < end_q;
		take_best    = scan_live && (lt_key || ((op_q == OP_LOOKUP) && eq_key)) &&
			(!best_found_q || gt_best);
		clear_hit    = scan_live && (op_q == OP_INSERT) && !lt_key && lt_end;
		scan_done    = (rd_cnt_q == LAST_CNT) && !rd_vld_s1;
		prev_overlap = best_found_q && (best_end_q > key_q) && (best_start_q < end_q);
		slot_ok      = match_found_q || free_found_q;
		slot_idx     = match_found_q ? match_idx_q : free_idx_q;
		mem_we       = (state_q == ST_WRITE) && slot_ok;
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[slot_idx] <= '{start_addr: key_q, end_addr: end_q, kind: kind_q};
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	// Sequencer, valid bits and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			rd_cnt_q      <= '0;
			rd_vld_s1     <= 1'b0;
			best_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			// Read issue for the scanning states.
			if ((state_q == ST_SCAN) || (state_q == ST_FIND_SLOT)) begin
				if (rd_cnt_q != LAST_CNT) begin
					rd_cnt_q  <= rd_cnt_q + 1'b1;
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= rd_addr;
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q          <= req.opcode;
						key_q         <= req.address;
						end_q         <= req.address + req.length;
						kind_q        <= kind_of(req.name_kind, req.exec_flag);
						rd_cnt_q      <= '0;
						rd_vld_s1     <= 1'b0;
						best_found_q  <= 1'b0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						case (req.opcode)
							OP_LOOKUP: state_q <= ST_SCAN;
							OP_INSERT: state_q <= ST_SCAN;
							OP_LOAD:   state_q <= ST_FIND_SLOT;
							default: begin
								hit_q       <= 1'b0;
								rstart_q    <= '0;
								rend_q      <= '0;
								rkind_q     <= RK_NONE;
								full_q      <= 1'b0;
								rsp_valid_q <= 1'b1;
								state_q     <= ST_RESP;
							end
						endcase
					end
				end

				// Best-candidate pass; an insert also drops entries that start inside the new region.
				ST_SCAN: begin
					if (take_best) begin
						best_found_q <= 1'b1;
						best_start_q <= rd_data_s1.start_addr;
						best_end_q   <= rd_data_s1.end_addr;
						best_kind_q  <= rd_data_s1.kind;
						best_idx_q   <= rd_idx_s1;
					end
					if (clear_hit) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end
					if (scan_done) begin
						state_q <= (op_q == OP_LOOKUP) ? ST_LOOKUP_END : ST_CLEAR_PREV;
					end
				end

				ST_LOOKUP_END: begin
					full_q <= 1'b0;
					if (best_found_q && (key_q < best_end_q)) begin
						hit_q    <= 1'b1;
						rstart_q <= best_start_q;
						rend_q   <= best_end_q;
						rkind_q  <= best_kind_q;
					end else begin
						hit_q    <= 1'b0;
						rstart_q <= '0;
						rend_q   <= '0;
						rkind_q  <= RK_NONE;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= ST_RESP;
				end

				// The region just below the new start is dropped if it reaches in.
				ST_CLEAR_PREV: begin
					if (prev_overlap) begin
						valid_q[best_idx_q] <= 1'b0;
					end
					rd_cnt_q  <= '0;
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_FIND_SLOT;
				end

				// Slot search: an entry with the same start, else the lowest free one.
				ST_FIND_SLOT: begin
					if (scan_live && eq_key && !match_found_q) begin
						match_found_q <= 1'b1;
						match_idx_q   <= rd_idx_s1;
					end
					if (rd_vld_s1 && !ent_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= rd_idx_s1;
					end
					if (scan_done) begin
						state_q <= ST_WRITE;
					end
				end

				ST_WRITE: begin
					if (slot_ok) begin
						valid_q[slot_idx] <= 1'b1;
					end
					hit_q       <= 1'b0;
					rstart_q    <= '0;
					rend_q      <= '0;
					rkind_q     <= RK_NONE;
					full_q      <= !slot_ok;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_RESP;
				end

				ST_RESP: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencing and on the response contents.
	`ART_ASSERT_IMP(a_ready_no_rsp, req.ready, !rsp.valid, "ready while a response is pending")
	`ART_ASSERT_NXT(a_busy_after_take, req.valid && req.ready, !req.ready, "ready right after a request")
	`ART_ASSERT_IMP(a_hit_not_full, rsp.valid && rsp.hit, !rsp.table_full, "hit and table_full together")
	`ART_ASSERT_IMP(a_miss_zero, rsp.valid && !rsp.hit, (rsp.region_start == '0) && (rsp.region_end == '0) && (rsp.region_kind == RK_NONE), "miss with region data")
	`ART_ASSERT_IMP(a_kind_range, rsp.valid && rsp.hit, rsp.region_kind <= RK_FILE_DATA, "region kind out of range")

endmodule

`default_nettype wire
